@@ rtl/wmm_pkg.sv @@
// ----------------------------------------------------------------------------
// wmm_pkg: shared types and constants
// Widths, register indexes, sequencer states and the divider handshake
// used by the waveform min/max column unit.
// ----------------------------------------------------------------------------
package wmm_pkg;

	// Default sizing of the sample store and column grid
	localparam int MAX_FRAMES_DEF   = 16384;
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int MAX_COLUMNS_DEF  = 16384;

	// Field and datapath widths
	localparam int POS_W    = 48;
	localparam int COLCNT_W = 15;
	localparam int FRAME_W  = 15;
	localparam int CHAN_W   = 4;
	localparam int FPS_W    = 32;
	localparam int COL_W    = 14;
	localparam int SMP_W    = 17;
	localparam int SADDR_W  = 17;
	localparam int SCAN_W   = FRAME_W + CHAN_W;
	localparam int NUM_W    = 64;
	localparam int DEN_W    = 32;
	localparam int MUL_W    = 32;

	localparam logic signed [SMP_W-1:0] ONE_Q15     = 17'sd32768;
	localparam logic signed [SMP_W-1:0] NEG_ONE_Q15 = -17'sd32768;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_COLUMN_COUNT  = 3'd0,
		REG_QUERY_START   = 3'd1,
		REG_QUERY_END     = 3'd2,
		REG_STORE_START   = 3'd3,
		REG_FRAME_COUNT   = 3'd4,
		REG_CHANNEL_COUNT = 3'd5,
		REG_FPS           = 3'd6
	} reg_idx_t;

	// Query sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPAN_DIV,
		ST_RANGE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_SUM,
		ST_DIV_S,
		ST_DIV_E,
		ST_FRAME_S,
		ST_FRAME_E,
		ST_LAST,
		ST_ADDR_S,
		ST_ADDR_E,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
		logic             rem_nz;
	} div_rsp_t;

endpackage

@@ rtl/wmm_div.sv @@
// ----------------------------------------------------------------------------
// wmm_div: iterative restoring divider
// One quotient bit per cycle; done is registered together with the last step.
// ----------------------------------------------------------------------------
module wmm_div import wmm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             ge;
	logic [DEN_W:0]   rem_next;

	// Trial subtract of the shifted remainder
	always_comb begin
		shifted  = {rem_q, quot_q[NUM_W-1]};
		ge       = shifted >= {1'b0, den_q};
		rem_next = ge ? (shifted - {1'b0, den_q}) : shifted;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.num;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= rem_next[DEN_W-1:0];
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quot   = quot_q;
	assign rsp.rem_nz = rem_q != '0;

endmodule

@@ rtl/wmm_mul.sv @@
// ----------------------------------------------------------------------------
// wmm_mul: shared registered multiplier
// Unsigned product of two operands, registered and available in the next cycle.
// ----------------------------------------------------------------------------
module wmm_mul import wmm_pkg::*; (
	input  logic               clk,
	input  logic [MUL_W-1:0]   a,
	input  logic [MUL_W-1:0]   b,
	output logic [2*MUL_W-1:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
	end

endmodule

@@ rtl/wmm_store.sv @@
// ----------------------------------------------------------------------------
// wmm_store: sample store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wmm_store import wmm_pkg::*; #(
	parameter int DEPTH  = MAX_FRAMES_DEF * MAX_CHANNELS_DEF,
	parameter int ADDR_W = 17
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [ADDR_W-1:0]       waddr,
	input  logic signed [SMP_W-1:0] wdata,
	input  logic [ADDR_W-1:0]       raddr,
	output logic signed [SMP_W-1:0] rdata_s1
);

	logic signed [SMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[raddr];
	end

endmodule

@@ rtl/waveform_min_max_columns_unit.sv @@
// ----------------------------------------------------------------------------
// waveform_min_max_columns_unit: min/max envelope of one display column
// Loads clamped samples into the store and, per query, walks the frames of
// one column to report the smallest and largest sample over all channels.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Contents
// s_*       in         tvalid/tready        tuser req_type, tdata sample/column
// m_*       out        tvalid/tready        tuser query_ok, tdata column result
// apb       in         psel/penable/pready  seven setup registers at 8*index
//
// Loads are written to the store as they are accepted. A query runs three
// divisions on the bit-serial divider, then reads the store one sample a
// cycle over every stored sample in the column (frames times channels).
// An invalid setup skips the divisions and goes straight to the answer.
// Reset clears control state and sets the configuration registers to their
// defaults; store contents stay undefined. A stalled result is held in the
// output register; a finished query waits only if the previous result has not been taken.
// ----------------------------------------------------------------------------
module waveform_min_max_columns_unit import wmm_pkg::*; #(
	parameter int MAX_FRAMES   = MAX_FRAMES_DEF,
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // sample_address[16:0], sample_value[33:17], column_index[47:34]
	input  logic        s_tuser,  // req_type
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // result_column[13:0], column_min[30:14], column_max[47:31]
	output logic        m_tuser,  // query_ok
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam longint STORE_DEPTH = longint'(MAX_FRAMES) * longint'(MAX_CHANNELS);
	localparam longint MEM_DEPTH   = (STORE_DEPTH < (longint'(1) << SADDR_W)) ?
		STORE_DEPTH : (longint'(1) << SADDR_W);
	localparam int     ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Configuration registers
	logic [COLCNT_W-1:0] column_count_q;
	logic [POS_W-1:0]    query_start_q;
	logic [POS_W-1:0]    query_end_q;
	logic [POS_W-1:0]    store_start_q;
	logic [FRAME_W-1:0]  frame_count_q;
	logic [CHAN_W-1:0]   channel_count_q;
	logic [FPS_W-1:0]    fps_q;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q  <= COLCNT_W'(1);
			query_start_q   <= '0;
			query_end_q     <= '0;
			store_start_q   <= '0;
			frame_count_q   <= '0;
			channel_count_q <= CHAN_W'(1);
			fps_q           <= FPS_W'(65536);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_COLUMN_COUNT:  column_count_q  <= pwdata[COLCNT_W-1:0];
				REG_QUERY_START:   query_start_q   <= pwdata[POS_W-1:0];
				REG_QUERY_END:     query_end_q     <= pwdata[POS_W-1:0];
				REG_STORE_START:   store_start_q   <= pwdata[POS_W-1:0];
				REG_FRAME_COUNT:   frame_count_q   <= pwdata[FRAME_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[CHAN_W-1:0];
				REG_FPS:           fps_q           <= pwdata[FPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (cfg_idx)
			REG_COLUMN_COUNT:  prdata = 64'(column_count_q);
			REG_QUERY_START:   prdata = 64'(query_start_q);
			REG_QUERY_END:     prdata = 64'(query_end_q);
			REG_STORE_START:   prdata = 64'(store_start_q);
			REG_FRAME_COUNT:   prdata = 64'(frame_count_q);
			REG_CHANNEL_COUNT: prdata = 64'(channel_count_q);
			REG_FPS:           prdata = 64'(fps_q);
			default:           prdata = '0;
		endcase
	end

	// Input fields
	logic [SADDR_W-1:0]      in_addr;
	logic signed [SMP_W-1:0] in_value;
	logic [COL_W-1:0]        in_col;
	logic signed [SMP_W-1:0] clamped;
	logic                    in_fire;
	logic                    load_we;

	assign in_addr  = s_tdata[16:0];
	assign in_value = s_tdata[33:17];
	assign in_col   = s_tdata[47:34];
	assign in_fire  = s_tvalid && s_tready;

	// Saturate to plus or minus one on load
	always_comb begin
		if (in_value > ONE_Q15) begin
			clamped = ONE_Q15;
		end else if (in_value < NEG_ONE_Q15) begin
			clamped = NEG_ONE_Q15;
		end else begin
			clamped = in_value;
		end
	end

	assign load_we = in_fire && !s_tuser && (longint'(in_addr) < MEM_DEPTH);

	// Setup checks for a query
	logic [COLCNT_W-1:0] cols_eff;
	logic                bad_setup;

	always_comb begin
		if (column_count_q == '0) begin
			cols_eff = COLCNT_W'(1);
		end else if (32'(column_count_q) > MAX_COLUMNS) begin
			cols_eff = COLCNT_W'(MAX_COLUMNS);
		end else begin
			cols_eff = column_count_q;
		end
		bad_setup = (frame_count_q == '0) || (32'(frame_count_q) > MAX_FRAMES) ||
			(channel_count_q == '0) || (32'(channel_count_q) > MAX_CHANNELS) ||
			(fps_q == '0) || (query_end_q <= query_start_q) ||
			({1'b0, in_col} >= cols_eff);
	end

	// Sequencer state and query registers
	state_t                  state_q, state_d;
	logic [COL_W-1:0]        col_q;
	logic [COLCNT_W-1:0]     cols_q;
	logic                    ok_q;
	logic [POS_W:0]          store_end_q;
	logic [POS_W-1:0]        lo_q;
	logic [POS_W-1:0]        span_q;
	logic [NUM_W-1:0]        prod_lo_q;
	logic [NUM_W-1:0]        num_s_q;
	logic [POS_W-1:0]        cs_q;
	logic [POS_W-1:0]        ce_q;
	logic                    big_q;
	logic [FRAME_W-1:0]      first_q;
	logic [FRAME_W-1:0]      last_q;
	logic [SCAN_W-1:0]       a_q;
	logic [SCAN_W-1:0]       a_end_q;
	logic signed [SMP_W-1:0] mn_q;
	logic signed [SMP_W-1:0] mx_q;
	logic                    rd_vld_s1;
	logic                    out_valid_q;
	logic [47:0]             out_data_q;
	logic                    out_ok_q;

	// Shared units
	div_req_t                div_req;
	div_rsp_t                div_rsp;
	logic [MUL_W-1:0]        mul_a;
	logic [MUL_W-1:0]        mul_b;
	logic [2*MUL_W-1:0]      mul_p_s1;
	logic signed [SMP_W-1:0] rdata_s1;

	wmm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	wmm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p_s1)
	);

	wmm_store #(
		.DEPTH  (int'(MEM_DEPTH)),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk      (clk),
		.we       (load_we),
		.waddr    (ADDR_W'(in_addr)),
		.wdata    (clamped),
		.raddr    (a_q[ADDR_W-1:0]),
		.rdata_s1 (rdata_s1)
	);

	// Combinational position arithmetic
	logic [POS_W-1:0]   lo_c;
	logic [POS_W-1:0]   hi_c;
	logic [NUM_W-1:0]   num_s_c;
	logic [POS_W-1:0]   ds_c;
	logic [POS_W-1:0]   de_c;
	logic [POS_W-1:0]   floor_c;
	logic [POS_W:0]     ceil_c;
	logic [FRAME_W-1:0] fcm1_c;
	logic [FRAME_W-1:0] f1_c;
	logic               out_free;

	always_comb begin
		lo_c    = (query_start_q > store_start_q) ? query_start_q : store_start_q;
		hi_c    = ((POS_W+1)'(query_end_q) < store_end_q) ? query_end_q :
			store_end_q[POS_W-1:0];
		num_s_c = prod_lo_q + {mul_p_s1[MUL_W-1:0], {MUL_W{1'b0}}};
		ds_c    = cs_q - store_start_q;
		de_c    = ce_q - store_start_q;
		floor_c = mul_p_s1[NUM_W-1:16];
		ceil_c  = (POS_W+1)'(mul_p_s1[NUM_W-1:16]) +
			(POS_W+1)'(mul_p_s1[15:0] != '0);
		fcm1_c  = frame_count_q - 1'b1;
		f1_c    = first_q + 1'b1;
	end

	assign out_free = !out_valid_q || m_tready;

	// Next state, divider requests and multiplier operands
	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.num   = num_s_q + NUM_W'(span_q);
		div_req.den   = DEN_W'(cols_q);
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && s_tuser) begin
					if (bad_setup) begin
						state_d = ST_DONE;
					end else begin
						div_req.start = 1'b1;
						div_req.num   = NUM_W'({frame_count_q, 16'h0000});
						div_req.den   = fps_q;
						state_d       = ST_SPAN_DIV;
					end
				end
			end
			ST_SPAN_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_RANGE;
				end
			end
			ST_RANGE: begin
				state_d = (hi_c <= lo_c) ? ST_DONE : ST_MUL_LO;
			end
			ST_MUL_LO: begin
				mul_a   = MUL_W'(col_q);
				mul_b   = span_q[MUL_W-1:0];
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				mul_a   = MUL_W'(col_q);
				mul_b   = MUL_W'(span_q[POS_W-1:MUL_W]);
				state_d = ST_MUL_SUM;
			end
			ST_MUL_SUM: begin
				div_req.start = 1'b1;
				div_req.num   = num_s_c;
				state_d       = ST_DIV_S;
			end
			ST_DIV_S: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV_E;
				end
			end
			ST_DIV_E: begin
				if (div_rsp.done) begin
					state_d = ST_FRAME_S;
				end
			end
			ST_FRAME_S: begin
				mul_a   = ds_c[MUL_W-1:0];
				mul_b   = fps_q;
				state_d = ST_FRAME_E;
			end
			ST_FRAME_E: begin
				mul_a   = de_c[MUL_W-1:0];
				mul_b   = fps_q;
				state_d = ST_LAST;
			end
			ST_LAST: begin
				mul_a   = MUL_W'(first_q);
				mul_b   = MUL_W'(channel_count_q);
				state_d = ST_ADDR_S;
			end
			ST_ADDR_S: begin
				mul_a   = MUL_W'(last_q);
				mul_b   = MUL_W'(channel_count_q);
				state_d = ST_ADDR_E;
			end
			ST_ADDR_E: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (a_q + 1'b1 == a_end_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = state_q == ST_IDLE;

	// Query datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q      <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= state_q == ST_SCAN;
			if (state_q == ST_IDLE && in_fire && s_tuser) begin
				ok_q <= !bad_setup;
			end else if (state_q == ST_RANGE && hi_c <= lo_c) begin
				ok_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				col_q  <= in_col;
				cols_q <= cols_eff;
			end
			ST_SPAN_DIV: begin
				store_end_q <= (POS_W+1)'(store_start_q) +
					(POS_W+1)'(div_rsp.quot[DEN_W-1:0]) + (POS_W+1)'(div_rsp.rem_nz);
			end
			ST_RANGE: begin
				lo_q   <= lo_c;
				span_q <= hi_c - lo_c;
			end
			ST_MUL_HI: begin
				prod_lo_q <= mul_p_s1;
			end
			ST_MUL_SUM: begin
				num_s_q <= num_s_c;
			end
			ST_DIV_S: begin
				cs_q <= lo_q + div_rsp.quot[POS_W-1:0];
			end
			ST_DIV_E: begin
				ce_q <= lo_q + div_rsp.quot[POS_W-1:0] + POS_W'(div_rsp.rem_nz);
			end
			ST_FRAME_S: begin
				big_q <= ds_c[POS_W-1:MUL_W] != '0;
			end
			ST_FRAME_E: begin
				// floor of the start frame, clamped below the frame count
				if (big_q || floor_c > POS_W'(fcm1_c)) begin
					first_q <= fcm1_c;
				end else begin
					first_q <= floor_c[FRAME_W-1:0];
				end
				big_q <= de_c[POS_W-1:MUL_W] != '0;
			end
			ST_LAST: begin
				// ceil of the end frame, at least one frame, at most the count
				if (big_q || ceil_c > (POS_W+1)'(frame_count_q)) begin
					last_q <= frame_count_q;
				end else if (ceil_c < (POS_W+1)'(f1_c)) begin
					last_q <= f1_c;
				end else begin
					last_q <= ceil_c[FRAME_W-1:0];
				end
			end
			ST_ADDR_S: begin
				a_q <= mul_p_s1[SCAN_W-1:0];
			end
			ST_ADDR_E: begin
				a_end_q <= mul_p_s1[SCAN_W-1:0];
				mn_q    <= ONE_Q15;
				mx_q    <= NEG_ONE_Q15;
			end
			ST_SCAN: begin
				a_q <= a_q + 1'b1;
			end
			default: ;
		endcase
		// fold each returned sample into the envelope
		if (rd_vld_s1) begin
			if (rdata_s1 < mn_q) begin
				mn_q <= rdata_s1;
			end
			if (rdata_s1 > mx_q) begin
				mx_q <= rdata_s1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_ok_q   <= ok_q;
			out_data_q <= {ok_q ? mx_q : '0, ok_q ? mn_q : '0, col_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ok_q;

endmodule

@@ rtl/wmm_check.sv @@
// ----------------------------------------------------------------------------
// wmm_check: port-level checks
// Watches the result stream of the column unit and is bound to its top.
// ----------------------------------------------------------------------------
module wmm_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// Keep a stalled result valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A failed query carries zero envelope values
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:14] == '0)
		else $error("failed query with nonzero values");

	// The envelope is ordered
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $signed(m_tdata[30:14]) <= $signed(m_tdata[47:31]))
		else $error("column min above column max");

	// The envelope stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> ($signed(m_tdata[47:31]) <= 17'sd32768) &&
			($signed(m_tdata[30:14]) >= -17'sd32768))
		else $error("envelope outside full scale");

endmodule

bind waveform_min_max_columns_unit wmm_check u_wmm_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
